### sv/bldc_pkg.sv
// Shared types, constants and CRC helpers for the binary log deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bldc_pkg;

  localparam int OFF_W = 17;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h44;
  localparam logic [7:0] SYNC_C = 8'h12;
  localparam logic [1:0] SYNC_LAST_IDX = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [7:0] MIN_HDR_LEN = 8'd20;
  localparam logic [17:0] TRAILER_LEN = 18'd4;

  // Frame status codes
  localparam logic [1:0] ST_CRC_GOOD  = 2'd0;
  localparam logic [1:0] ST_CRC_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT_HDR = 2'd2;

  // Header byte positions, counted from the first sync byte
  localparam logic [OFF_W-1:0] POS_HLEN     = 17'd3;
  localparam logic [OFF_W-1:0] POS_MSG_LO   = 17'd4;
  localparam logic [OFF_W-1:0] POS_MSG_HI   = 17'd5;
  localparam logic [OFF_W-1:0] POS_PLEN_LO  = 17'd8;
  localparam logic [OFF_W-1:0] POS_PLEN_HI  = 17'd9;
  localparam logic [OFF_W-1:0] POS_WEEK_LO  = 17'd14;
  localparam logic [OFF_W-1:0] POS_WEEK_HI  = 17'd15;
  localparam logic [OFF_W-1:0] POS_MS_0     = 17'd16;
  localparam logic [OFF_W-1:0] POS_MS_1     = 17'd17;
  localparam logic [OFF_W-1:0] POS_MS_2     = 17'd18;
  localparam logic [OFF_W-1:0] POS_MS_3     = 17'd19;

  localparam int RQ_DEPTH = 2;

  // One result queue entry; a sync entry expands into three transfers.
  typedef struct packed {
    logic              sync;
    logic [7:0]        frame_byte;
    logic [OFF_W-1:0]  byte_offset;
    logic              last_byte;
    logic [1:0]        frame_status;
    logic [15:0]       message_id;
    logic [7:0]        header_length;
    logic [15:0]       payload_length;
    logic [15:0]       gps_week;
    logic [31:0]       week_millis;
  } rq_entry_t;

  // Reflected CRC-32, one byte, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = SYNC_A;
      2'd1: b = SYNC_B;
      default: b = SYNC_C;
    endcase
    return b;
  endfunction

  // CRC after the three sync bytes, starting from zero
  localparam logic [31:0] CRC_SYNC = crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B),
                                              SYNC_C);

endpackage

### sv/bldc_rq.sv
// Small result queue between the frame parser and the output port.
// Depends on bldc_pkg for the entry type.
`timescale 1ns / 1ps

module bldc_rq #(
  parameter int DEPTH = bldc_pkg::RQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bldc_pkg::rq_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output bldc_pkg::rq_entry_t head,
  output logic                empty
);
  import bldc_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rq_entry_t         mem_r [DEPTH];
  logic [IW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + IW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + IW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/binary_log_deframer_crc32.sv
// Top level of the binary log deframer with reflected CRC-32 frame check.
// Depends on bldc_pkg and bldc_rq.
`timescale 1ns / 1ps

// The block takes one raw byte per transfer and sustains one byte per clock
// while the result queue has room. An accepted byte lands in an input
// register; the parser (sync hunt, header capture, one-byte CRC-32 update,
// trailer compare) works on it once the queue is not full and pushes at most
// one entry into a result queue of QUEUE_DEPTH entries, which feeds the
// output port. in_ready depends only on registered state, never
// combinationally on out_ready. An input byte reaches the output port through
// the input register and the result queue. A completed sync pattern AA 44 12
// is one queue entry that leaves as three output transfers (offsets 0, 1,
// 2), so the output side falls behind at each frame start and input stalls
// only once the queue fills. Every later frame byte is one output transfer.
// The last byte of a frame carries the status (CRC good, CRC mismatch, or
// short header when byte 3 is below 20) along with message id, lengths, week
// and millisecond time; these fields read zero on all other bytes. After a
// frame ends, hunting resumes with the next byte and no frame byte can start
// a new sync match.

module binary_log_deframer_crc32 #(
  parameter int QUEUE_DEPTH = bldc_pkg::RQ_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_frame_byte,
  output logic [bldc_pkg::OFF_W-1:0]    out_byte_offset,
  output logic                          out_last_byte,
  output logic [1:0]                    out_frame_status,
  output logic [15:0]                   out_message_id,
  output logic [7:0]                    out_header_length,
  output logic [15:0]                   out_payload_length,
  output logic [15:0]                   out_gps_week,
  output logic signed [31:0]            out_week_millis
);
  import bldc_pkg::*;

  // Input register
  logic        in_v_r;
  logic [7:0]  in_byte_r;

  // Parser state
  logic [15:0]      recent_r, recent_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [OFF_W-1:0] pos_r, pos_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic [15:0]      pay_r, pay_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      trl_r, trl_nxt;
  logic [15:0]      msg_r, msg_nxt;
  logic [15:0]      week_r, week_nxt;
  logic [31:0]      millis_r, millis_nxt;

  logic [OFF_W-1:0] body;
  logic [OFF_W-1:0] trl_idx;
  logic [17:0]      total;
  logic [17:0]      pos_p1;

  logic       proc_fire;
  logic       q_push, q_full, q_pop, q_empty;
  rq_entry_t  q_in, q_head;
  logic [1:0] sub_r;
  logic       out_fire;

  assign in_ready  = !in_v_r || !q_full;
  assign proc_fire = in_v_r && !q_full;

  // Hold the byte until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (proc_fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  // Parser: one byte per cycle while the result queue has room
  always_comb begin
    recent_nxt   = recent_r;
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    hdr_nxt      = hdr_r;
    pay_nxt      = pay_r;
    crc_nxt      = crc_r;
    trl_nxt      = trl_r;
    msg_nxt      = msg_r;
    week_nxt     = week_r;
    millis_nxt   = millis_r;
    q_push       = 1'b0;
    q_in         = '0;
    body         = '0;
    total        = '0;
    pos_p1       = {1'b0, pos_r} + 18'd1;
    trl_idx      = '0;

    if (!in_frame_r) begin
      if (recent_r == {SYNC_A, SYNC_B} && in_byte_r == SYNC_C) begin
        // Sync complete: queue the three sync bytes as one entry
        q_push       = 1'b1;
        q_in.sync    = 1'b1;
        crc_nxt      = CRC_SYNC;
        trl_nxt      = '0;
        hdr_nxt      = '0;
        pay_nxt      = '0;
        msg_nxt      = '0;
        week_nxt     = '0;
        millis_nxt   = '0;
        in_frame_nxt = 1'b1;
        pos_nxt      = POS_HLEN;
        recent_nxt   = '0;
      end else begin
        recent_nxt = {recent_r[7:0], in_byte_r};
      end
    end else begin
      q_push           = 1'b1;
      q_in.frame_byte  = in_byte_r;
      q_in.byte_offset = pos_r;

      // Capture header fields by position
      case (pos_r)
        POS_HLEN:    hdr_nxt           = in_byte_r;
        POS_MSG_LO:  msg_nxt[7:0]      = in_byte_r;
        POS_MSG_HI:  msg_nxt[15:8]     = in_byte_r;
        POS_PLEN_LO: pay_nxt[7:0]      = in_byte_r;
        POS_PLEN_HI: pay_nxt[15:8]     = in_byte_r;
        POS_WEEK_LO: week_nxt[7:0]     = in_byte_r;
        POS_WEEK_HI: week_nxt[15:8]    = in_byte_r;
        POS_MS_0:    millis_nxt[7:0]   = in_byte_r;
        POS_MS_1:    millis_nxt[15:8]  = in_byte_r;
        POS_MS_2:    millis_nxt[23:16] = in_byte_r;
        POS_MS_3:    millis_nxt[31:24] = in_byte_r;
        default: ;
      endcase

      if (pos_r == POS_HLEN && in_byte_r < MIN_HDR_LEN) begin
        // Short header: end the frame here, nothing else has arrived
        q_in.last_byte     = 1'b1;
        q_in.frame_status  = ST_SHORT_HDR;
        q_in.header_length = in_byte_r;
        in_frame_nxt       = 1'b0;
        pos_nxt            = '0;
        recent_nxt         = '0;
      end else begin
        body    = {9'd0, hdr_nxt} + {1'b0, pay_nxt};
        total   = {1'b0, body} + TRAILER_LEN;
        trl_idx = pos_r - body;

        if (pos_r < body) begin
          crc_nxt = crc_byte(crc_r, in_byte_r);
        end else if (trl_idx < OFF_W'(4)) begin
          trl_nxt[{trl_idx[1:0], 3'b000} +: 8] = in_byte_r;
        end

        if (pos_p1 >= total) begin
          q_in.last_byte      = 1'b1;
          q_in.frame_status   = (crc_nxt == trl_nxt) ? ST_CRC_GOOD : ST_CRC_BAD;
          q_in.message_id     = msg_nxt;
          q_in.header_length  = hdr_nxt;
          q_in.payload_length = pay_nxt;
          q_in.gps_week       = week_nxt;
          q_in.week_millis    = millis_nxt;
          in_frame_nxt        = 1'b0;
          pos_nxt             = '0;
          recent_nxt          = '0;
        end else begin
          pos_nxt = pos_p1[OFF_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r   <= '0;
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else if (proc_fire) begin
      recent_r   <= recent_nxt;
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Header fields, CRC and trailer; at sync the CRC is preset to the sync value and the rest cleared before use
  always_ff @(posedge clk) begin
    if (proc_fire) begin
      hdr_r    <= hdr_nxt;
      pay_r    <= pay_nxt;
      crc_r    <= crc_nxt;
      trl_r    <= trl_nxt;
      msg_r    <= msg_nxt;
      week_r   <= week_nxt;
      millis_r <= millis_nxt;
    end
  end

  bldc_rq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (proc_fire && q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Output side: expand a sync entry into three transfers
  assign out_valid = !q_empty;
  assign out_fire  = out_valid && out_ready;
  assign q_pop     = out_fire && (!q_head.sync || sub_r == SYNC_LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
    end else if (out_fire) begin
      sub_r <= q_pop ? 2'd0 : sub_r + 2'd1;
    end
  end

  always_comb begin
    if (q_head.sync) begin
      out_frame_byte     = sync_byte(sub_r);
      out_byte_offset    = {{(OFF_W-2){1'b0}}, sub_r};
      out_last_byte      = 1'b0;
      out_frame_status   = ST_CRC_GOOD;
      out_message_id     = '0;
      out_header_length  = '0;
      out_payload_length = '0;
      out_gps_week       = '0;
      out_week_millis    = '0;
    end else begin
      out_frame_byte     = q_head.frame_byte;
      out_byte_offset    = q_head.byte_offset;
      out_last_byte      = q_head.last_byte;
      out_frame_status   = q_head.frame_status;
      out_message_id     = q_head.message_id;
      out_header_length  = q_head.header_length;
      out_payload_length = q_head.payload_length;
      out_gps_week       = q_head.gps_week;
      out_week_millis    = signed'(q_head.week_millis);
    end
  end

endmodule

### sv/bldc_chk.sv
// Port-level checks for the binary log deframer, bound to the top level.
// Depends on bldc_pkg for status codes and limits.
`timescale 1ns / 1ps

module bldc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   out_frame_byte,
  input logic [bldc_pkg::OFF_W-1:0]   out_byte_offset,
  input logic                         out_last_byte,
  input logic [1:0]                   out_frame_status,
  input logic [15:0]                  out_message_id,
  input logic [7:0]                   out_header_length,
  input logic [15:0]                  out_payload_length,
  input logic [15:0]                  out_gps_week,
  input logic signed [31:0]           out_week_millis
);
  import bldc_pkg::*;

  // Short header status only for a header length below the minimum
  a_short_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte && out_frame_status == ST_SHORT_HDR
      |-> out_header_length < MIN_HDR_LEN)
    else $error("short header status with a legal header length");

  // Summary fields read zero on every byte but the last
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte
      |-> out_frame_status == ST_CRC_GOOD && out_message_id == '0 &&
          out_header_length == '0 && out_payload_length == '0 &&
          out_gps_week == '0 && out_week_millis == '0)
    else $error("summary fields nonzero on a non-final byte");

  // The first sync byte transfer is followed right away by the second
  a_sync_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_byte_offset == '0
      |=> out_valid && out_byte_offset == OFF_W'(1) && out_frame_byte == SYNC_B)
    else $error("sync bytes not delivered back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
      |=> out_valid && $stable(out_frame_byte) && $stable(out_byte_offset))
    else $error("result changed while stalled");

endmodule

bind binary_log_deframer_crc32 bldc_chk u_bldc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_frame_byte     (out_frame_byte),
  .out_byte_offset    (out_byte_offset),
  .out_last_byte      (out_last_byte),
  .out_frame_status   (out_frame_status),
  .out_message_id     (out_message_id),
  .out_header_length  (out_header_length),
  .out_payload_length (out_payload_length),
  .out_gps_week       (out_gps_week),
  .out_week_millis    (out_week_millis)
);
